[rtl/tczn_pkg.sv]
// shared types and constants for the two-channel z-score normalizer
`timescale 1ns / 1ps
`default_nettype none
package tczn_pkg;
  localparam int unsigned MaxTrainSamples = 1024;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned ReqW = 2;
  localparam int unsigned StatusW = 3;

  localparam logic [ReqW-1:0] REQ_TRAIN   = 2'd0;
  localparam logic [ReqW-1:0] REQ_NORM    = 2'd1;
  localparam logic [ReqW-1:0] REQ_RESTART = 2'd2;

  localparam logic [StatusW-1:0] ST_STORED   = 3'd0;
  localparam logic [StatusW-1:0] ST_DONE     = 3'd1;
  localparam logic [StatusW-1:0] ST_VALID    = 3'd2;
  localparam logic [StatusW-1:0] ST_UNTRAIN  = 3'd3;
  localparam logic [StatusW-1:0] ST_ZERODEV  = 3'd4;
  localparam logic [StatusW-1:0] ST_IGNORED  = 3'd5;

  // lane operation codes
  typedef enum logic [2:0] {
    OP_SUM  = 3'b001,
    OP_SQ   = 3'b010,
    OP_DIV  = 3'b100
  } lane_op_t;

  typedef struct packed {
    logic     go;
    lane_op_t op;
  } lane_ctl_t;
endpackage
`default_nettype wire

[rtl/tczn_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tczn_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/tczn_lane.sv]
// one channel lane: accumulates, squares and runs a serial divider
`timescale 1ns / 1ps
`default_nettype none
module tczn_lane (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tczn_pkg::lane_ctl_t  ctl,
  input  wire logic                 clr,
  input  wire logic                 acc_en,
  input  wire logic signed [31:0]   sample,
  input  wire logic signed [31:0]   mean_in,
  input  wire logic [127:0]         dividend,
  input  wire logic [63:0]          divisor,
  output logic signed [63:0]        sum,
  output logic [127:0]              sqsum,
  output logic [127:0]              quot,
  output logic                      div_busy
);
  import tczn_pkg::*;
  logic [63:0]  mag;
  logic [127:0] sq;
  logic [127:0] rem;
  logic [6:0]   cnt;
  logic [128:0] trial;
  logic signed [32:0] dif;

  // deviation is registered before the multiply
  always_comb begin
    dif = 33'(sample) - 33'(mean_in);
    trial = {rem, quot[127]} - {65'd0, divisor};
  end

  always_ff @(posedge clk) begin
    mag <= dif[32] ? 64'(-dif) : 64'(dif);
    sq <= 128'(mag[32:0]) * 128'(mag[32:0]);
    if (clr) begin
      sum <= '0;
      sqsum <= '0;
    end else if (acc_en) begin
      if (ctl.op == OP_SUM) sum <= sum + 64'(sample);
      else if (ctl.op == OP_SQ) sqsum <= sqsum + sq;
    end
    if (rst) begin
      div_busy <= 1'b0;
      cnt <= '0;
    end else if (ctl.go && ctl.op == OP_DIV) begin
      div_busy <= 1'b1;
      cnt <= 7'd127;
      quot <= dividend;
      rem <= '0;
    end else if (div_busy) begin
      if (!trial[128]) begin
        rem <= trial[127:0];
        quot <= {quot[126:0], 1'b1};
      end else begin
        rem <= {rem[126:0], quot[127]};
        quot <= {quot[126:0], 1'b0};
      end
      if (cnt == 0) div_busy <= 1'b0;
      else cnt <= cnt - 7'd1;
    end
  end
endmodule
`default_nettype wire

[rtl/tczn_sqrt.sv]
// bit-serial integer square root of a 64-bit value
`timescale 1ns / 1ps
`default_nettype none
module tczn_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [63:0] val,
  output logic [31:0]      root,
  output logic             busy
);
  logic [63:0] rad;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic [33:0] trial;
  always_comb trial = {rem[31:0], rad[63:62]} - {root, 2'b01};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (go) begin
      busy <= 1'b1;
      rad <= val;
      rem <= '0;
      root <= '0;
      cnt <= 5'd31;
    end else if (busy) begin
      rad <= {rad[61:0], 2'b00};
      if (!trial[33]) begin
        rem <= trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem <= {rem[31:0], rad[63:62]};
        root <= {root[30:0], 1'b0};
      end
      if (cnt == 0) busy <= 1'b0;
      else cnt <= cnt - 5'd1;
    end
  end
endmodule
`default_nettype wire

[rtl/two_channel_zscore_normalizer.sv]
// top level: sequencer, sample store, two channel lanes and merging stage
//
// channel   direction  signals
// command   in         start, busy, req_type, feature_a, feature_b
// result    out        done, score, status
// config    in         cfg_valid, cfg_ready, cfg_data
//
// normalize runs the 128-step divider; the end of a training pass runs store
// reads, two 128-bit divides and two roots.
// rst is synchronous; results are strobed by done, the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module two_channel_zscore_normalizer #(
  parameter int unsigned MaxTrain = tczn_pkg::MaxTrainSamples
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               req_type,
  input  wire logic signed [31:0]       feature_a,
  input  wire logic signed [31:0]       feature_b,
  output logic                          done,
  output logic signed [31:0]            score,
  output logic [2:0]                    status,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [10:0]              cfg_data
);
  import tczn_pkg::*;
  localparam int unsigned AW = $clog2(MaxTrain);
  localparam int unsigned NW = AW + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SUM   = 9'b000000010,
    S_MEAN  = 9'b000000100,
    S_MEANW = 9'b000001000,
    S_SQ    = 9'b000010000,
    S_VAR   = 9'b000100000,
    S_ROOT  = 9'b001000000,
    S_ZDIV  = 9'b010000000,
    S_ZOUT  = 9'b100000000
  } state_t;

  state_t state;
  logic [10:0] train_count;
  logic [NW-1:0] taken, n, rd_idx, limit;
  logic [AW-1:0] addr;
  logic we;
  logic [63:0] rdata;
  logic signed [31:0] mean_a, mean_b, new_mean_a, new_mean_b;
  logic [31:0] dev_a, dev_b, root_a_keep;
  logic trained, in_flight;
  logic [2:0] pipe;
  logic root_ch;
  logic neg_a, neg_b;
  lane_ctl_t ctl;
  logic acc_en, clr;
  logic signed [63:0] sum_a, sum_b;
  logic [127:0] sq_a, sq_b, q_a, q_b, dvd_a, dvd_b;
  logic [63:0] dvs_a, dvs_b;
  logic busy_a, busy_b, sq_busy, sq_go;
  logic [31:0] root;
  logic [63:0] sq_val;
  logic signed [31:0] lane_mean_a, lane_mean_b, smp_a, smp_b;
  logic [63:0] mag_sa, mag_sb;
  logic signed [65:0] zsum;
  logic signed [65:0] zhalf;
  logic [NW-1:0] cnt_eff;
  logic [NW-1:0] idx_eff;

  always_comb begin
    cnt_eff = (train_count == 0) ? NW'(1)
            : (32'(train_count) > MaxTrain) ? NW'(MaxTrain) : NW'(train_count);
    idx_eff = (32'(taken) >= MaxTrain) ? NW'(MaxTrain - 1) : taken;
  end

  assign busy = (state != S_IDLE) || in_flight;
  assign cfg_ready = !busy;

  tczn_ram #(.Width(64), .Depth(MaxTrain)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata({feature_b, feature_a}), .rdata(rdata)
  );

  always_comb begin
    we = (state == S_IDLE) && start && !in_flight && (req_type == REQ_TRAIN);
    addr = we ? idx_eff[AW-1:0] : rd_idx[AW-1:0];
    smp_a = (state == S_ZDIV || state == S_IDLE) ? feature_a : rdata[31:0];
    smp_b = (state == S_ZDIV || state == S_IDLE) ? feature_b : rdata[63:32];
  end

  always_comb begin
    lane_mean_a = (state == S_SQ) ? new_mean_a : mean_a;
    lane_mean_b = (state == S_SQ) ? new_mean_b : mean_b;
    mag_sa = 64'(lane_mean_a);
    mag_sb = 64'(lane_mean_b);
  end

  // mean: sum / n via the lane dividers, sign handled here
  logic [63:0] abs_sa, abs_sb;
  assign abs_sa = sum_a[63] ? 64'(-sum_a) : 64'(sum_a);
  assign abs_sb = sum_b[63] ? 64'(-sum_b) : 64'(sum_b);

  // normalize: dividend |x-mean|<<16 from registered magnitudes
  logic [63:0] zmag_a, zmag_b;
  always_comb begin
    if (state == S_MEAN) begin
      dvd_a = 128'(abs_sa);
      dvd_b = 128'(abs_sb);
    end else if (state == S_VAR) begin
      dvd_a = sq_a;
      dvd_b = sq_b;
    end else begin
      dvd_a = 128'(zmag_a) << 16;
      dvd_b = 128'(zmag_b) << 16;
    end
    dvs_a = (state == S_VAR || state == S_MEAN) ? 64'(n) : 64'(dev_a);
    dvs_b = (state == S_VAR || state == S_MEAN) ? 64'(n) : 64'(dev_b);
  end

  tczn_lane u_lane_a (
    .clk(clk), .rst(rst), .ctl(ctl), .clr(clr), .acc_en(acc_en), .sample(smp_a),
    .mean_in(lane_mean_a), .dividend(dvd_a), .divisor(dvs_a), .sum(sum_a),
    .sqsum(sq_a), .quot(q_a), .div_busy(busy_a)
  );
  tczn_lane u_lane_b (
    .clk(clk), .rst(rst), .ctl(ctl), .clr(clr), .acc_en(acc_en), .sample(smp_b),
    .mean_in(lane_mean_b), .dividend(dvd_b), .divisor(dvs_b), .sum(sum_b),
    .sqsum(sq_b), .quot(q_b), .div_busy(busy_b)
  );

  assign sq_val = root_ch ? q_b[63:0] : q_a[63:0];
  tczn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .go(sq_go), .val(sq_val), .root(root), .busy(sq_busy)
  );

  always_comb begin
    zsum = (neg_a ? -66'(q_a[47:0]) : 66'(q_a[47:0]))
         + (neg_b ? -66'(q_b[47:0]) : 66'(q_b[47:0]));
    zhalf = (zsum < 0) ? -((-zsum) >>> 1) : (zsum >>> 1);
  end

  logic mean_phase;
  always_ff @(posedge clk) begin
    ctl.go <= 1'b0;
    clr <= 1'b0;
    acc_en <= 1'b0;
    sq_go <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      train_count <= 11'd1024;
      taken <= '0;
      mean_a <= '0; mean_b <= '0; dev_a <= '0; dev_b <= '0;
      trained <= 1'b0;
      in_flight <= 1'b0;
      ctl.op <= OP_SUM;
      mean_phase <= 1'b0;
      root_ch <= 1'b0;
    end else begin
      in_flight <= 1'b0;
      if (cfg_valid && cfg_ready) train_count <= cfg_data;
      unique case (state)
        S_IDLE: if (start && !in_flight) begin
          in_flight <= 1'b1;
          score <= '0;
          if (req_type == REQ_TRAIN) begin
            if (idx_eff + NW'(1) >= cnt_eff) begin
              n <= idx_eff + NW'(1);
              taken <= '0;
              limit <= idx_eff;
              rd_idx <= '0;
              clr <= 1'b1;
              ctl.op <= OP_SUM;
              pipe <= '0;
              state <= S_SUM;
              in_flight <= 1'b0;
            end else begin
              taken <= idx_eff + NW'(1);
              status <= ST_STORED;
              done <= 1'b1;
            end
          end else if (req_type == REQ_NORM) begin
            if (!trained) begin
              status <= ST_UNTRAIN; done <= 1'b1;
            end else if (dev_a == 0 || dev_b == 0) begin
              status <= ST_ZERODEV; done <= 1'b1;
            end else begin
              zmag_a <= 64'(feature_a) - mag_sa;
              zmag_b <= 64'(feature_b) - mag_sb;
              in_flight <= 1'b0;
              state <= S_ZDIV;
              pipe <= '0;
            end
          end else if (req_type == REQ_RESTART) begin
            taken <= '0; mean_a <= '0; mean_b <= '0; dev_a <= '0; dev_b <= '0;
            trained <= 1'b0;
            status <= ST_STORED; done <= 1'b1;
          end else begin
            status <= ST_IGNORED; done <= 1'b1;
          end
        end
        S_SUM, S_SQ: begin
          // read address runs ahead; sums use the registered read, squares the read, magnitude and square registers
          if (rd_idx <= limit) rd_idx <= rd_idx + NW'(1);
          pipe <= {pipe[1:0], (rd_idx <= limit)};
          acc_en <= (state == S_SUM) ? (rd_idx <= limit) : pipe[1];
          if (pipe == 3'b000 && rd_idx > limit && !acc_en) begin
            if (state == S_SUM) begin
              state <= S_MEAN;
              mean_phase <= 1'b1;
            end else begin
              ctl.go <= 1'b1; ctl.op <= OP_DIV;
              mean_phase <= 1'b0;
              state <= S_VAR;
            end
          end
        end
        S_MEAN: begin
          if (mean_phase) begin
            ctl.op <= OP_DIV; ctl.go <= 1'b1; mean_phase <= 1'b0;
          end else if (!ctl.go && !busy_a && !busy_b) begin
            state <= S_MEANW;
          end
        end
        S_MEANW: begin
          new_mean_a <= sum_a[63] ? -32'(q_a[31:0]) : 32'(q_a[31:0]);
          new_mean_b <= sum_b[63] ? -32'(q_b[31:0]) : 32'(q_b[31:0]);
          rd_idx <= '0; pipe <= '0; ctl.op <= OP_SQ;
          state <= S_SQ;
        end
        S_VAR: if (!ctl.go && !busy_a && !busy_b) begin
          sq_go <= 1'b1; root_ch <= 1'b0; state <= S_ROOT;
        end
        S_ROOT: if (!sq_go && !sq_busy) begin
          if (!root_ch) begin
            root_a_keep <= root; root_ch <= 1'b1; sq_go <= 1'b1;
          end else begin
            dev_a <= root_a_keep; dev_b <= root;
            mean_a <= new_mean_a; mean_b <= new_mean_b;
            trained <= 1'b1;
            status <= ST_DONE; done <= 1'b1; state <= S_IDLE;
          end
        end
        S_ZDIV: begin
          if (pipe == 3'b000) begin
            neg_a <= zmag_a[63]; neg_b <= zmag_b[63];
            zmag_a <= zmag_a[63] ? -zmag_a : zmag_a;
            zmag_b <= zmag_b[63] ? -zmag_b : zmag_b;
            pipe <= 3'b001;
          end else if (pipe == 3'b001) begin
            ctl.op <= OP_DIV; ctl.go <= 1'b1; pipe <= 3'b011;
          end else if (!ctl.go && !busy_a && !busy_b) begin
            state <= S_ZOUT;
          end
        end
        S_ZOUT: begin
          score <= (zhalf > 66'sd2147483647) ? 32'h7FFFFFFF
                 : (zhalf < -66'sd2147483648) ? 32'h80000000 : zhalf[31:0];
          status <= ST_VALID; done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction without busy");
  assert property (@(posedge clk) disable iff (rst)
    done && status == ST_VALID |-> trained) else $error("score without training");
  assert property (@(posedge clk) disable iff (rst)
    done && status != ST_VALID |-> score == 0) else $error("nonzero score");
  assert property (@(posedge clk) disable iff (rst)
    we |-> !busy) else $error("store write while busy");
endmodule
`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for the two-channel z-score normalizer
`timescale 1ns / 1ps
module testbench;
  import tczn_pkg::*;

  localparam logic [ReqW-1:0] REQ_NONE = 2'd3;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned ItemTarget = 1400;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    logic signed [31:0] score;
    logic [2:0] status;
  } zresult_t;

  typedef struct {
    row_kind_t kind;
    logic [1:0] req;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit typed;
    logic signed [31:0] score;
    logic [2:0] status;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] req_type = '0;
  logic signed [31:0] feature_a = '0;
  logic signed [31:0] feature_b = '0;
  logic cfg_valid = 0;
  logic [10:0] cfg_data = '0;
  logic busy, done, cfg_ready;
  logic signed [31:0] score;
  logic [2:0] status;

  always #5 clk = ~clk;

  two_channel_zscore_normalizer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .feature_a(feature_a), .feature_b(feature_b),
    .done(done), .score(score), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow of the block state
  logic signed [31:0] pair_a [0:MaxTrainSamples-1];
  logic signed [31:0] pair_b [0:MaxTrainSamples-1];
  int unsigned pairs_held;
  logic signed [31:0] avg_a, avg_b;
  logic [31:0] sdev_a, sdev_b;
  bit stats_ready;
  logic [10:0] pass_len;

  zresult_t pending_scores[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int passes_done = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] rem, root, pos;
    rem = v;
    root = 0;
    pos = 64'h1 << 62;
    while (pos > rem) pos = pos >> 2;
    while (pos != 0) begin
      if (rem >= root + pos) begin
        rem = rem - (root + pos);
        root = (root >> 1) + pos;
      end else begin
        root = root >> 1;
      end
      pos = pos >> 2;
    end
    return root;
  endfunction

  function automatic void channel_moments(int unsigned n, bit chan_b,
                                          output logic signed [31:0] avg,
                                          output logic [31:0] sdev);
    longint sum;
    longint d;
    logic [63:0] mag;
    logic [127:0] acc, quo;
    logic signed [31:0] x;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      x = chan_b ? pair_b[i] : pair_a[i];
      sum = sum + longint'(x);
    end
    avg = 32'(sum / longint'(n));
    acc = 0;
    for (int i = 0; i < n; i++) begin
      x = chan_b ? pair_b[i] : pair_a[i];
      d = longint'(x) - longint'(avg);
      mag = d < 0 ? 64'(-d) : 64'(d);
      acc = acc + 128'(mag) * 128'(mag);
    end
    quo = acc / 128'(n);
    sdev = 32'(floor_sqrt(quo[63:0]));
  endfunction

  function automatic longint zvalue(logic signed [31:0] x, logic signed [31:0] avg,
                                    logic [31:0] sdev);
    longint d;
    logic [63:0] mag, z;
    d = longint'(x) - longint'(avg);
    mag = d < 0 ? 64'(-d) : 64'(d);
    z = (mag << 16) / {32'b0, sdev};
    return d < 0 ? -longint'(z) : longint'(z);
  endfunction

  function automatic zresult_t predict_zscore(logic [1:0] req, logic signed [31:0] a,
                                              logic signed [31:0] b);
    zresult_t r;
    int unsigned cnt;
    longint s;
    r.score = 0;
    r.status = ST_IGNORED;
    case (req)
      REQ_TRAIN: begin
        cnt = pass_len;
        if (cnt == 0) cnt = 1;
        if (cnt > MaxTrainSamples) cnt = MaxTrainSamples;
        if (pairs_held >= MaxTrainSamples) pairs_held = MaxTrainSamples - 1;
        pair_a[pairs_held] = a;
        pair_b[pairs_held] = b;
        pairs_held++;
        if (pairs_held >= cnt) begin
          channel_moments(pairs_held, 0, avg_a, sdev_a);
          channel_moments(pairs_held, 1, avg_b, sdev_b);
          stats_ready = 1;
          pairs_held = 0;
          r.status = ST_DONE;
        end else begin
          r.status = ST_STORED;
        end
      end
      REQ_NORM: begin
        if (!stats_ready) begin
          r.status = ST_UNTRAIN;
        end else if (sdev_a == 0 || sdev_b == 0) begin
          r.status = ST_ZERODEV;
        end else begin
          s = (zvalue(a, avg_a, sdev_a) + zvalue(b, avg_b, sdev_b)) / 2;
          if (s > longint'(SMAX)) s = longint'(SMAX);
          if (s < longint'(SMIN)) s = longint'(SMIN);
          r.score = 32'(s);
          r.status = ST_VALID;
        end
      end
      REQ_RESTART: begin
        pairs_held = 0;
        avg_a = 0;
        avg_b = 0;
        sdev_a = 0;
        sdev_b = 0;
        stats_ready = 0;
        r.status = ST_STORED;
      end
      default: ;
    endcase
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(logic [1:0] req, logic signed [31:0] a, logic signed [31:0] b,
                           bit typed, zresult_t typed_res);
    int gap;
    zresult_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    start <= 1;
    req_type <= req;
    feature_a <= a;
    feature_b <= b;
    do @(posedge clk); while (busy);
    r = predict_zscore(req, a, b);
    if (r.status == ST_DONE) passes_done++;
    pending_scores.push_back(typed ? typed_res : r);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_train_count(logic [10:0] v);
    start <= 0;
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    pass_len = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_feature(logic signed [31:0] center);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return center + 32'($urandom_range(0, 4095)) - 32'sd2048;
      2: return $urandom_range(0, 1) ? SMAX : SMIN;
      default: return 32'($urandom_range(0, 32'h1fffff)) - 32'sh100000;
    endcase
  endfunction

  function automatic logic [1:0] pick_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return REQ_TRAIN;
    if (r < 88) return REQ_NORM;
    if (r < 93) return REQ_RESTART;
    return REQ_NONE;
  endfunction

  // result checker
  always @(posedge clk) begin
    zresult_t e;
    if (!rst && done) begin
      results_seen++;
      if (pending_scores.size() == 0) begin
        $display("%0t unexpected result: actual score %h status %0d", $time, score, status);
        errors++;
      end else begin
        e = pending_scores.pop_front();
        if (score !== e.score) begin
          $display("%0t score mismatch: expected %h actual %h", $time, e.score, score);
          errors++;
        end
        if (status !== e.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t row(row_kind_t k, logic [1:0] q, logic signed [31:0] a,
                                    logic signed [31:0] b, bit t,
                                    logic signed [31:0] s, logic [2:0] st);
    stim_row_t x;
    x.kind = k;
    x.req = q;
    x.a = a;
    x.b = b;
    x.typed = t;
    x.score = s;
    x.status = st;
    return x;
  endfunction

  initial begin
    zresult_t tr;
    logic [10:0] cnt;
    int unsigned eff;
    int phase;
    logic signed [31:0] center;

    pairs_held = 0;
    avg_a = 0;
    avg_b = 0;
    sdev_a = 0;
    sdev_b = 0;
    stats_ready = 0;
    pass_len = 11'd1024;

    directed.push_back(row(ROW_ITEM, REQ_NORM, 0, 0, 1, 0, ST_UNTRAIN));
    directed.push_back(row(ROW_ITEM, REQ_NONE, SMAX, SMIN, 1, 0, ST_IGNORED));
    directed.push_back(row(ROW_ITEM, REQ_RESTART, SMIN, SMAX, 1, 0, ST_STORED));
    directed.push_back(row(ROW_CFG, 0, 1, 0, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, 5, 7, 1, 0, ST_DONE));
    directed.push_back(row(ROW_ITEM, REQ_NORM, 5, 7, 1, 0, ST_ZERODEV));
    directed.push_back(row(ROW_CFG, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, -1, -1, 1, 0, ST_DONE));
    directed.push_back(row(ROW_CFG, 0, 2, 0, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, SMAX, SMIN, 1, 0, ST_STORED));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, SMIN, SMAX, 1, 0, ST_DONE));
    directed.push_back(row(ROW_ITEM, REQ_NORM, 0, 0, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_NORM, SMAX, SMIN, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_NORM, SMIN, SMAX, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, 0, 0, 1, 0, ST_STORED));
    directed.push_back(row(ROW_ITEM, REQ_NORM, 12345, -678, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, 4, 4, 1, 0, ST_DONE));
    directed.push_back(row(ROW_ITEM, REQ_NORM, SMAX, SMAX, 1, SMAX, ST_VALID));
    directed.push_back(row(ROW_ITEM, REQ_NORM, SMIN, SMIN, 1, SMIN, ST_VALID));
    directed.push_back(row(ROW_ITEM, REQ_NORM, 3, 1, 0, 0, 0));
    directed.push_back(row(ROW_CFG, 0, 4, 0, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, 1, 2, 1, 0, ST_STORED));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, 3, 4, 1, 0, ST_STORED));
    directed.push_back(row(ROW_CFG, 0, 2, 0, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_TRAIN, 5, 9, 1, 0, ST_DONE));
    directed.push_back(row(ROW_ITEM, REQ_NORM, 2, -3, 0, 0, 0));
    directed.push_back(row(ROW_ITEM, REQ_RESTART, 0, 0, 1, 0, ST_STORED));
    directed.push_back(row(ROW_ITEM, REQ_NORM, 7, 7, 1, 0, ST_UNTRAIN));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_train_count(11'(directed[i].a));
      end else begin
        tr.score = directed[i].score;
        tr.status = directed[i].status;
        send_item(directed[i].req, directed[i].a, directed[i].b, directed[i].typed, tr);
      end
    end

    phase = 0;
    while (items_sent < ItemTarget) begin
      if (phase == 3) cnt = 11'd2047;
      else if ($urandom_range(0, 9) == 0) cnt = 11'($urandom_range(17, 64));
      else cnt = 11'($urandom_range(0, 16));
      write_train_count(cnt);
      center = $urandom;
      if (phase == 3) begin
        repeat (MaxTrainSamples)
          send_item(REQ_TRAIN, pick_feature(center), pick_feature(center), 0, tr);
        repeat (6) send_item(REQ_NORM, pick_feature(center), pick_feature(center), 0, tr);
      end else begin
        eff = cnt == 0 ? 1 : cnt;
        repeat (eff + $urandom_range(0, 10))
          send_item(pick_req(), pick_feature(center), pick_feature(center), 0, tr);
      end
      phase++;
    end

    start <= 0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d items, %0d results, %0d training passes, %0d count writes",
             items_sent, results_seen, passes_done, cfg_writes);
    if (errors == 0 && pending_scores.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results still owed", errors, pending_scores.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
